// ===== rtl/core/utf8_char_segmenter_core_assert.svh =====
// Assertion macros shared by the segmenter RTL.
`ifndef UTF8_CHAR_SEGMENTER_CORE_ASSERT_SVH
`define UTF8_CHAR_SEGMENTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/u8seg_pkg.sv =====
`default_nettype none
package u8seg_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIFO_DEPTH      = 8;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 64;

  localparam logic [16:0] SEL_PREFIX = 17'h00fe0;
  localparam logic [20:0] OVL2_LIMIT = 21'h000080;
  localparam logic [20:0] OVL3_MAX   = 21'h0007ff;
  localparam logic [20:0] OVL4_MAX   = 21'h00ffff;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        has_selector;
    logic [3:0]  selector_index;
    logic [15:0] error_total;
    logic [15:0] variant_total;
    logic        last;
  } res_t;

  function automatic res_t char_res(input logic [20:0] cp, input logic [2:0] len,
                                    input logic sel, input logic [3:0] idx);
    res_t r;
    r                = '0;
    r.kind           = KIND_CHAR;
    r.code_point     = cp;
    r.byte_count     = len;
    r.has_selector   = sel;
    r.selector_index = idx;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/utf8_char_segmenter_core.sv =====
// An accepted byte waits in the input register, is decoded combinationally once the FIFO
// has room, and its results are written to the result FIFO, whose head drives out_tdata.
// Throughput: one byte per cycle while the FIFO has room; results leave one per output
// handshake through the single read port of the 8-entry result FIFO.
// in_tready drops only while a byte waits in the input register and the FIFO has fewer
// than 3 free entries. Reset: synchronous, active-low rst_n clears decode state, counters,
// skip mode and FIFO.
`default_nettype none
`include "utf8_char_segmenter_core_assert.svh"
module utf8_char_segmenter_core #(
  parameter int COUNT_WIDTH = u8seg_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_wr_data,  // skip_single_byte
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [u8seg_pkg::IN_TDATA_W-1:0]  in_tdata,     // [7:0] data_byte
  input  wire logic                              in_tlast,     // end_of_string
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [20:0] code_point, [23:21] byte_count, [24] has_selector, [28:25] selector_index,
  // [44:29] error_total, [60:45] variant_total, [63:61] zero
  output logic [u8seg_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tuser,    // result_kind
  output logic                                   out_tlast     // last
);
  import u8seg_pkg::*;

  logic       skip_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;
  logic       room;
  logic       proc;
  logic       in_acc;
  logic [1:0] push_n;
  res_t [2:0] push_data;
  res_t       head;

  assign proc      = in_v_r && room;
  assign in_tready = !in_v_r || room;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
      in_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (proc) begin
        in_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata[7:0];
      in_eos_r  <= in_tlast;
    end
  end

  u8seg_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .skip_i   (skip_r),
    .proc_i   (proc),
    .byte_i   (in_byte_r),
    .eos_i    (in_eos_r),
    .push_n_o (push_n),
    .res_o    (push_data)
  );

  u8seg_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .room_o      (room),
    .valid_o     (out_tvalid),
    .pop_i       (out_tready),
    .head_o      (head)
  );

  assign out_tdata = {3'b000, head.variant_total, head.error_total, head.selector_index,
                      head.has_selector, head.byte_count, head.code_point};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  `ASSERT_NEXT(a_in_hold, in_v_r && !proc, in_v_r && $stable(in_byte_r) && $stable(in_eos_r), "stalled byte lost")

endmodule
`default_nettype wire

// ===== rtl/core/u8seg_decode.sv =====
`default_nettype none
`include "utf8_char_segmenter_core_assert.svh"
module u8seg_decode #(
  parameter int COUNT_WIDTH = u8seg_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    skip_i,
  input  wire logic                    proc_i,
  input  wire logic [7:0]              byte_i,
  input  wire logic                    eos_i,
  output logic [1:0]                   push_n_o,
  output u8seg_pkg::res_t [2:0]        res_o
);
  import u8seg_pkg::*;

  logic [20:0]            grp_bits_r, grp_bits_nxt;
  logic [1:0]             grp_need_r, grp_need_nxt;
  logic [2:0]             grp_seen_r, grp_seen_nxt;
  logic [20:0]            held_code_r, held_code_nxt;
  logic [2:0]             held_len_r, held_len_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [COUNT_WIDTH-1:0] err_cnt_r, err_cnt_nxt;
  logic [COUNT_WIDTH-1:0] var_cnt_r, var_cnt_nxt;
  logic [1:0]             nres;
  res_t [2:0]             res;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] cnt,
                                                     input logic [2:0] n);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, cnt} + (COUNT_WIDTH+1)'(n);
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] to_total(input logic [COUNT_WIDTH-1:0] cnt);
    logic [COUNT_WIDTH+15:0] w;
    w = {16'b0, cnt};
    return w[15:0];
  endfunction

  always_comb begin
    logic        cont;
    logic        done;
    logic        overlong;
    logic        is_sel;
    res_t        summ;
    grp_bits_nxt   = grp_bits_r;
    grp_need_nxt   = grp_need_r;
    grp_seen_nxt   = grp_seen_r;
    held_code_nxt  = held_code_r;
    held_len_nxt   = held_len_r;
    held_valid_nxt = held_valid_r;
    err_cnt_nxt    = err_cnt_r;
    var_cnt_nxt    = var_cnt_r;
    nres           = 2'd0;
    res            = '0;
    done           = 1'b0;
    overlong       = 1'b0;
    is_sel         = 1'b0;
    summ           = '0;
    cont           = (byte_i[7:6] == 2'b10);

    if (grp_need_nxt != 2'd0) begin
      if (cont) begin
        done         = 1'b1;
        grp_bits_nxt = {grp_bits_nxt[14:0], byte_i[5:0]};
        grp_seen_nxt = grp_seen_nxt + 3'd1;
        grp_need_nxt = grp_need_nxt - 2'd1;
        if (grp_need_nxt == 2'd0) begin
          overlong = (grp_seen_nxt == 3'd2 && grp_bits_nxt <  OVL2_LIMIT) ||
                     (grp_seen_nxt == 3'd3 && grp_bits_nxt <= OVL3_MAX) ||
                     (grp_seen_nxt == 3'd4 && grp_bits_nxt <= OVL4_MAX);
          is_sel   = (grp_bits_nxt[20:4] == SEL_PREFIX);
          if (overlong) begin
            if (held_valid_nxt) begin
              res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b0, 4'd0);
              nres           = nres + 2'd1;
              held_valid_nxt = 1'b0;
            end
            err_cnt_nxt = sat_add(err_cnt_nxt, grp_seen_nxt);
          end else if (held_valid_nxt && is_sel) begin
            // merge the selector into the held base character
            res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b1, grp_bits_nxt[3:0]);
            nres           = nres + 2'd1;
            held_valid_nxt = 1'b0;
            var_cnt_nxt    = sat_add(var_cnt_nxt, 3'd1);
          end else begin
            if (held_valid_nxt) begin
              res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b0, 4'd0);
              nres           = nres + 2'd1;
              held_valid_nxt = 1'b0;
            end
            if (is_sel) begin
              res[nres] = char_res(grp_bits_nxt, grp_seen_nxt, 1'b0, 4'd0);
              nres      = nres + 2'd1;
            end else begin
              held_code_nxt  = grp_bits_nxt;
              held_len_nxt   = grp_seen_nxt;
              held_valid_nxt = 1'b1;
            end
          end
          grp_bits_nxt = '0;
          grp_seen_nxt = '0;
        end
      end else begin
        // broken group: its bytes are errors, the breaking byte is taken afresh
        if (held_valid_nxt) begin
          res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b0, 4'd0);
          nres           = nres + 2'd1;
          held_valid_nxt = 1'b0;
        end
        err_cnt_nxt  = sat_add(err_cnt_nxt, grp_seen_nxt);
        grp_bits_nxt = '0;
        grp_seen_nxt = '0;
        grp_need_nxt = '0;
      end
    end

    if (!done) begin
      if (!byte_i[7]) begin
        if (held_valid_nxt) begin
          res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b0, 4'd0);
          nres           = nres + 2'd1;
          held_valid_nxt = 1'b0;
        end
        if (!skip_i) begin
          res[nres] = char_res({13'd0, byte_i}, 3'd1, 1'b0, 4'd0);
          nres      = nres + 2'd1;
        end
      end else if (cont || byte_i[7:3] == 5'b11111 || byte_i[7:1] == 7'b1100000) begin
        if (held_valid_nxt) begin
          res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b0, 4'd0);
          nres           = nres + 2'd1;
          held_valid_nxt = 1'b0;
        end
        err_cnt_nxt = sat_add(err_cnt_nxt, 3'd1);
      end else begin
        if (!byte_i[5]) begin
          grp_bits_nxt = {16'd0, byte_i[4:0]};
          grp_need_nxt = 2'd1;
        end else if (!byte_i[4]) begin
          grp_bits_nxt = {17'd0, byte_i[3:0]};
          grp_need_nxt = 2'd2;
        end else begin
          grp_bits_nxt = {18'd0, byte_i[2:0]};
          grp_need_nxt = 2'd3;
        end
        grp_seen_nxt = 3'd1;
      end
    end

    if (eos_i) begin
      if (grp_need_nxt != 2'd0) begin
        err_cnt_nxt  = sat_add(err_cnt_nxt, grp_seen_nxt);
        grp_bits_nxt = '0;
        grp_seen_nxt = '0;
        grp_need_nxt = '0;
      end
      if (held_valid_nxt) begin
        res[nres]      = char_res(held_code_nxt, held_len_nxt, 1'b0, 4'd0);
        nres           = nres + 2'd1;
        held_valid_nxt = 1'b0;
      end
      summ.kind          = KIND_SUMMARY;
      summ.error_total   = to_total(err_cnt_nxt);
      summ.variant_total = to_total(var_cnt_nxt);
      res[nres]          = summ;
      nres               = nres + 2'd1;
      err_cnt_nxt        = '0;
      var_cnt_nxt        = '0;
    end

    if (nres != 2'd0) begin
      res[nres - 2'd1].last = 1'b1;
    end
  end

  assign push_n_o = proc_i ? nres : 2'd0;
  assign res_o    = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_bits_r   <= '0;
      grp_need_r   <= '0;
      grp_seen_r   <= '0;
      held_code_r  <= '0;
      held_len_r   <= '0;
      held_valid_r <= 1'b0;
      err_cnt_r    <= '0;
      var_cnt_r    <= '0;
    end else if (proc_i) begin
      grp_bits_r   <= grp_bits_nxt;
      grp_need_r   <= grp_need_nxt;
      grp_seen_r   <= grp_seen_nxt;
      held_code_r  <= held_code_nxt;
      held_len_r   <= held_len_nxt;
      held_valid_r <= held_valid_nxt;
      err_cnt_r    <= err_cnt_nxt;
      var_cnt_r    <= var_cnt_nxt;
    end
  end

  `ASSERT_CLK(a_open_group_seen, (grp_need_r != 2'd0) == (grp_seen_r != 3'd0), "group count mismatch")

endmodule
`default_nettype wire

// ===== rtl/core/u8seg_fifo.sv =====
`default_nettype none
`include "utf8_char_segmenter_core_assert.svh"
module u8seg_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [1:0]              push_n_i,
  input  wire u8seg_pkg::res_t [2:0]   push_data_i,
  output logic                         room_o,
  output logic                         valid_o,
  input  wire logic                    pop_i,
  output u8seg_pkg::res_t              head_o
);
  import u8seg_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(FIFO_DEPTH - 3);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(FIFO_DEPTH);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign pop       = pop_i && valid_o;
  assign valid_o   = (count_r != '0);
  assign room_o    = (count_r <= ROOM_MAX);
  assign head_o    = mem[rd_ptr_r];
  assign count_nxt = count_r + CNT_W'(push_n_i) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(push_n_i)) begin
        mem[wr_ptr_r + PTR_W'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n_i);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  `ASSERT_CLK(a_push_room, push_n_i != 2'd0 |-> room_o, "push without room")
  `ASSERT_CLK(a_count_bound, count_r <= DEPTH_C, "fifo overflow")
  `ASSERT_CLK(a_count_track, $past(rst_n) |-> count_r == CNT_W'($past(count_r) + CNT_W'($past(push_n_i)) - CNT_W'($past(pop))), "count drift")

endmodule
`default_nettype wire

// ===== verif/tb_utf8_char_segmenter_core.sv =====
`timescale 1ns / 100ps
module tb_utf8_char_segmenter_core;
  import u8seg_pkg::*;

  localparam int          CYCLE_LIMIT = 50_000;
  localparam int          DRAIN_PAD   = 8;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  utf8_char_segmenter_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Segmenter model state
  logic        skip_mode = 1'b0;
  logic [20:0] grp_bits = '0;
  logic [1:0]  grp_need = '0;
  logic [2:0]  grp_seen = '0;
  logic [20:0] held_cp = '0;
  logic [2:0]  held_len = '0;
  logic        held_vld = 1'b0;
  logic [15:0] err_cnt = '0;
  logic [15:0] var_cnt = '0;
  res_t        step_res [3];
  int          step_n;

  res_t pending_segments [$];

  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int items_sent = 0;
  int strings_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycles = 0;

  task automatic push_res(input kind_t k, input logic [20:0] cp, input logic [2:0] len,
                          input logic sel, input logic [3:0] idx,
                          input logic [15:0] errs, input logic [15:0] vars);
    res_t r;
    r                = '0;
    r.kind           = k;
    r.code_point     = cp;
    r.byte_count     = len;
    r.has_selector   = sel;
    r.selector_index = idx;
    r.error_total    = errs;
    r.variant_total  = vars;
    if (step_n < 3) begin
      step_res[step_n] = r;
      step_n = step_n + 1;
    end
  endtask

  task automatic add_errors(input logic [2:0] n);
    logic [16:0] sum;
    sum = {1'b0, err_cnt} + {14'd0, n};
    err_cnt = sum[16] ? COUNT_MAX : sum[15:0];
  endtask

  task automatic flush_held();
    if (held_vld) begin
      push_res(KIND_CHAR, held_cp, held_len, 1'b0, 4'd0, 16'd0, 16'd0);
      held_vld = 1'b0;
    end
  endtask

  task automatic drop_group();
    grp_bits = '0;
    grp_seen = '0;
    grp_need = '0;
  endtask

  task automatic complete_group();
    logic [2:0]  len;
    logic [20:0] cp;
    logic        overlong;
    logic        is_sel;
    len      = grp_seen;
    cp       = grp_bits;
    overlong = (len == 3'd2 && cp < OVL2_LIMIT) || (len == 3'd3 && cp <= OVL3_MAX) ||
               (len == 3'd4 && cp <= OVL4_MAX);
    is_sel   = (cp[20:4] == SEL_PREFIX);
    drop_group();
    if (overlong) begin
      flush_held();
      add_errors(len);
    end else if (held_vld && is_sel) begin
      push_res(KIND_CHAR, held_cp, held_len, 1'b1, cp[3:0], 16'd0, 16'd0);
      held_vld = 1'b0;
      if (var_cnt != COUNT_MAX) var_cnt = var_cnt + 16'd1;
    end else begin
      flush_held();
      if (is_sel) begin
        push_res(KIND_CHAR, cp, len, 1'b0, 4'd0, 16'd0, 16'd0);
      end else begin
        held_cp  = cp;
        held_len = len;
        held_vld = 1'b1;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (grp_need != 2'd0 && b[7:6] == 2'b10) begin
      grp_bits = {grp_bits[14:0], b[5:0]};
      grp_seen = grp_seen + 3'd1;
      grp_need = grp_need - 2'd1;
      if (grp_need == 2'd0) complete_group();
    end else begin
      // a byte that breaks an open group voids the group, then is decoded afresh
      if (grp_need != 2'd0) begin
        flush_held();
        add_errors(grp_seen);
        drop_group();
      end
      if (!b[7]) begin
        flush_held();
        if (!skip_mode) push_res(KIND_CHAR, {13'd0, b}, 3'd1, 1'b0, 4'd0, 16'd0, 16'd0);
      end else if (b[7:6] == 2'b10 || b >= 8'hF8 || b == 8'hC0 || b == 8'hC1) begin
        flush_held();
        add_errors(3'd1);
      end else begin
        if (!b[5]) begin
          grp_bits = {16'd0, b[4:0]};
          grp_need = 2'd1;
        end else if (!b[4]) begin
          grp_bits = {17'd0, b[3:0]};
          grp_need = 2'd2;
        end else begin
          grp_bits = {18'd0, b[2:0]};
          grp_need = 2'd3;
        end
        grp_seen = 3'd1;
      end
    end
  endtask

  task automatic segment_byte(input logic [7:0] b, input logic eos);
    res_t r;
    step_n = 0;
    take_byte(b);
    if (eos) begin
      if (grp_need != 2'd0) begin
        flush_held();
        add_errors(grp_seen);
        drop_group();
      end
      flush_held();
      push_res(KIND_SUMMARY, 21'd0, 3'd0, 1'b0, 4'd0, err_cnt, var_cnt);
      err_cnt = '0;
      var_cnt = '0;
    end
    for (int i = 0; i < step_n; i++) begin
      r      = step_res[i];
      r.last = (i == step_n - 1);
      pending_segments.push_back(r);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (in_idle_on && $urandom_range(0, 99) < 25) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eos;
    do @(posedge clk); while (!in_tready);
    segment_byte(b, eos);
    items_sent = items_sent + 1;
    if (eos) strings_sent = strings_sent + 1;
    @(negedge clk);
  endtask

  // Bytes go out lowest first.
  task automatic send_seq(input logic [63:0] seq, input int n, input bit eos);
    for (int i = 0; i < n; i++) send_byte(seq[8*i +: 8], eos && (i == n - 1));
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (pending_segments.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_skip(input logic v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    skip_mode   = v;
  endtask

  function automatic logic [31:0] utf8_encode(input logic [20:0] cp, input int len);
    case (len)
      2:       return {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      3:       return {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    endcase
  endfunction

  function automatic logic [20:0] valid_cp(input int len);
    case (len)
      2:       return 21'($urandom_range(32'h80, 32'h7FF));
      3:       return 21'($urandom_range(32'h800, 32'hFFFF));
      default: return 21'($urandom_range(32'h10000, 32'h1FFFFF));
    endcase
  endfunction

  task automatic send_rand_token(input bit eos);
    int          pick;
    int          len;
    logic [63:0] seq;
    int          n;
    logic [20:0] cp;
    logic [31:0] base_enc;
    logic [31:0] sel_enc;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    if (pick < 20) begin
      seq = 64'($urandom_range(0, 127));
      n   = 1;
    end else if (pick < 42) begin
      seq = {32'd0, utf8_encode(valid_cp(len), len)};
      n   = len;
    end else if (pick < 55) begin
      seq = {32'd0, utf8_encode(21'h00FE00 + 21'($urandom_range(0, 15)), 3)};
      n   = 3;
    end else if (pick < 70) begin
      // base character directly followed by a selector
      base_enc = utf8_encode(valid_cp(len), len);
      sel_enc  = utf8_encode(21'h00FE00 + 21'($urandom_range(0, 15)), 3);
      case (len)
        4:       seq = {8'd0, sel_enc[23:0], base_enc};
        3:       seq = {16'd0, sel_enc[23:0], base_enc[23:0]};
        default: seq = {24'd0, sel_enc[23:0], base_enc[15:0]};
      endcase
      n   = len + 3;
    end else if (pick < 80) begin
      seq = 64'($urandom_range(0, 255));
      n   = 1;
    end else if (pick < 90) begin
      // truncated group, left open for the next token or the string end
      seq = {32'd0, utf8_encode(valid_cp(len), len)};
      n   = $urandom_range(1, len - 1);
    end else begin
      case (len)
        2:       cp = 21'($urandom_range(0, 32'h7F));
        3:       cp = 21'($urandom_range(0, 32'h7FF));
        default: cp = 21'($urandom_range(0, 32'hFFFF));
      endcase
      seq = {32'd0, utf8_encode(cp, len)};
      n   = len;
    end
    send_seq(seq, n, eos);
  endtask

  task automatic test_directed_decode();
    send_byte(8'h00, 1'b0);
    send_seq(64'hBF_DF, 2, 1'b0);           // U+07FF, held
    send_seq(64'h80_B8_EF, 3, 1'b0);        // merges with U+FE00
    send_byte(8'h80, 1'b0);                 // stray continuation
    send_byte(8'hC1, 1'b0);                 // overlong two-byte lead
    send_byte(8'hF8, 1'b0);                 // lead too long
    send_seq(64'h41_E0, 2, 1'b0);           // missing continuation, 'A' decoded afresh
    send_seq(64'hBF_9F_E0, 3, 1'b0);        // overlong three-byte form
    send_seq(64'h80_80_80_F5, 4, 1'b0);     // above U+10FFFF, held
    send_byte(8'hFF, 1'b0);                 // held character goes out alone
    send_seq(64'h80_A0_ED, 3, 1'b0);        // surrogate, held to string end
    send_seq(64'h90_F0, 2, 1'b1);           // group still open at string end
  endtask

  task automatic test_skip_mode();
    wait_drain();
    write_skip(1'b1);
    send_byte(8'h41, 1'b0);
    send_seq(64'hBF_BF_BF_F7, 4, 1'b0);     // U+1FFFFF
    send_seq(64'h8F_B8_EF, 3, 1'b0);        // merges with U+FE0F
    send_seq(64'h81_B8_EF, 3, 1'b0);        // selector with nothing held
    send_seq(64'hBF_BF_8F_F0, 4, 1'b1);     // overlong four-byte form
  endtask

  task automatic test_random_phase(input logic skip, input bit idle_on, input int n_items);
    int start;
    wait_drain();
    write_skip(skip);
    in_idle_on  = idle_on;
    out_idle_on = idle_on;
    start       = items_sent;
    while (items_sent - start < n_items) send_rand_token($urandom_range(0, 11) == 0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_counter_restart();
    wait_drain();
    write_skip(1'b0);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (3) send_seq(64'h80_B8_EF_80_C2, 5, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    // counters must restart from zero after the summary
    send_seq(64'h80_81_B8_EF_80_C2, 6, 1'b1);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    out_tready = !out_idle_on || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got                = '0;
      got.kind           = kind_t'(out_tuser);
      got.code_point     = out_tdata[20:0];
      got.byte_count     = out_tdata[23:21];
      got.has_selector   = out_tdata[24];
      got.selector_index = out_tdata[28:25];
      got.error_total    = out_tdata[44:29];
      got.variant_total  = out_tdata[60:45];
      got.last           = out_tlast;
      results_checked    = results_checked + 1;
      if (pending_segments.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("result with nothing pending: kind=%0d cp=%h len=%0d", got.kind,
                   got.code_point, got.byte_count);
      end else begin
        want = pending_segments.pop_front();
        if (got !== want || out_tdata[63:61] !== 3'b000) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch exp: kind=%0d cp=%h len=%0d sel=%0d/%h err=%0d var=%0d last=%0d",
                     want.kind, want.code_point, want.byte_count, want.has_selector,
                     want.selector_index, want.error_total, want.variant_total, want.last,
                     "\n         got: kind=%0d cp=%h len=%0d sel=%0d/%h err=%0d var=%0d last=%0d",
                     got.kind, got.code_point, got.byte_count, got.has_selector,
                     got.selector_index, got.error_total, got.variant_total, got.last,
                     " pad=%b", out_tdata[63:61]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_segments.size());
      $display("** utf8_char_segmenter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_decode();
    test_skip_mode();
    test_random_phase(1'b0, 1'b1, 85);
    test_random_phase(1'b1, 1'b1, 80);
    test_random_phase(1'b0, 1'b0, 85);
    test_random_phase(1'b1, 1'b1, 80);
    test_counter_restart();
    wait_drain();
    mismatches = mismatches + pending_segments.size();
    $display("covered: %0d bytes in %0d strings, %0d results checked, %0d mismatches",
             items_sent, strings_sent, results_checked, mismatches);
    $display("scope: every special case, both skip settings, random idling, counter clearing");
    if (mismatches == 0) begin
      $display("** utf8_char_segmenter_core: PASSED **");
    end else begin
      $display("** utf8_char_segmenter_core: FAILED **");
    end
    $finish;
  end

endmodule
